[hw/rtl/lgts_pkg.sv]
// Package for the topic sampler: sizes, field widths, codes and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
package lgts_pkg;

	localparam int TOPICS     = 64;
	localparam int VOCAB      = 65536;
	localparam int DOCS       = 4096;
	localparam int COUNT_BITS = 20;

	localparam int TOPIC_BITS   = $clog2(TOPICS);
	localparam int WORD_BITS    = $clog2(VOCAB);
	localparam int DOC_BITS     = $clog2(DOCS);
	localparam int K_BITS       = $clog2(TOPICS + 1);
	localparam int WT_ADDR_BITS = WORD_BITS + TOPIC_BITS;
	localparam int DT_ADDR_BITS = DOC_BITS + TOPIC_BITS;
	localparam int CLR_BITS     = (WT_ADDR_BITS > DT_ADDR_BITS) ? WT_ADDR_BITS : DT_ADDR_BITS;

	localparam int MODE_W   = 2;
	localparam int DOC_W    = 12;
	localparam int WORD_W   = 16;
	localparam int TOPIC_W  = 6;
	localparam int RND_W    = 16;
	localparam int OUT_W    = 20;
	localparam int PRIOR_W  = 24;
	localparam int KREG_W   = 7;
	localparam int VREG_W   = 17;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;

	localparam int FRAC_BITS = 16;
	localparam int Q_BITS    = 32;
	localparam int NUM_BITS  = COUNT_BITS + FRAC_BITS + 1;
	localparam int DEN_BITS  = ((COUNT_BITS + FRAC_BITS > VREG_W + PRIOR_W) ?
		COUNT_BITS + FRAC_BITS : VREG_W + PRIOR_W) + 1;
	localparam int CMP_BITS  = DEN_BITS + FRAC_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [PRIOR_W-1:0] ALPHA_RESET  = PRIOR_W'(6554);
	localparam logic [PRIOR_W-1:0] BETA_RESET   = PRIOR_W'(655);
	localparam logic [KREG_W-1:0]  TOPICS_RESET = KREG_W'(64);
	localparam logic [VREG_W-1:0]  VOCAB_RESET  = VREG_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA, REG_BETA, REG_TOPICS, REG_VOCAB
	} reg_index_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD, MODE_RESAMPLE, MODE_READ, MODE_SPARE
	} mode_t;

	typedef enum logic [1:0] {
		ADDR_TOKEN, ADDR_LOOP, ADDR_CLEAR
	} addr_sel_t;

	typedef struct packed {
		logic      capture;
		addr_sel_t addr_sel;
		logic      rd_cnt;
		logic      wr_dec;
		logic      wr_inc;
		logic      clr_wr;
		logic      res_zero;
		logic      res_rd;
		logic      div_start;
		logic      mul;
		logic      acc;
		logic      thr;
		logic      scan_rd;
		logic      pick;
		logic      i_inc;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic  bad_index;
		mode_t mode;
		logic  div_done;
		logic  hit;
		logic  i_last;
		logic  clr_last;
		logic  out_free;
	} stat_t;

endpackage

[hw/rtl/lgts_if.sv]
// Token and result channel interfaces of the topic sampler.
// Depends on lgts_pkg for field widths.
`timescale 1ns / 1ps
interface lgts_token_if;
	import lgts_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [MODE_W-1:0]    mode;
	logic [DOC_W-1:0]     doc_index;
	logic [WORD_W-1:0]    word_id;
	logic [TOPIC_W-1:0]   old_topic;
	logic [RND_W-1:0]     random_fraction;
	modport source (output valid, mode, doc_index, word_id, old_topic, random_fraction,
		input ready);
	modport sink (input valid, mode, doc_index, word_id, old_topic, random_fraction,
		output ready);
endinterface

interface lgts_result_if;
	import lgts_pkg::*;
	logic               valid;
	logic               ready;
	logic [TOPIC_W-1:0] new_topic;
	logic [OUT_W-1:0]   word_topic_count;
	logic [OUT_W-1:0]   topic_total;
	logic [OUT_W-1:0]   doc_topic_count;
	logic [OUT_W-1:0]   doc_length;
	modport source (output valid, new_topic, word_topic_count, topic_total,
		doc_topic_count, doc_length, input ready);
	modport sink (input valid, new_topic, word_topic_count, topic_total,
		doc_topic_count, doc_length, output ready);
endinterface

[hw/rtl/lda_gibbs_topic_sampler.sv]
// Top level of the collapsed Gibbs topic sampler.
// Depends on lgts_pkg, lgts_if, lgts_ctrl and lgts_datapath.
//
// After reset the block sweeps its count memories to zero, one entry per cycle,
// and takes no token beat until the sweep is done; configuration writes are
// taken throughout. Tokens are handled one at a time. Mode 0 is add, modes 2
// and 3 are read. In mode 1 (resample) each topic in use costs a memory read,
// a run of the two bit-serial dividers and one multiply-accumulate, and the
// draw then scans the stored cumulative weights one topic at a time. A new
// token beat is taken while the previous result still waits in the output
// register.
`timescale 1ns / 1ps
module lda_gibbs_topic_sampler (
	input  logic                           clk,
	input  logic                           arst_n,
	lgts_token_if.sink                     token,
	lgts_result_if.source                  result,
	input  logic                           cfg_we,
	input  logic [lgts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lgts_pkg::CFG_W-1:0]     cfg_data
);
	import lgts_pkg::*;

	cmd_t  cmd;
	stat_t status;
	logic  tok_ready;

	assign token.ready = tok_ready;

	lgts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_valid(token.valid),
		.tok_ready(tok_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lgts_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.tok_mode (token.mode),
		.tok_doc  (token.doc_index),
		.tok_word (token.word_id),
		.tok_topic(token.old_topic),
		.tok_rnd  (token.random_fraction),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule

[hw/rtl/lgts_div.sv]
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den),
// clipped to 32 bits. Depends on lgts_pkg.
`timescale 1ns / 1ps
module lgts_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lgts_pkg::NUM_BITS-1:0] num,
	input  logic [lgts_pkg::DEN_BITS-1:0] den,
	output logic                          busy,
	output logic [lgts_pkg::Q_BITS-1:0]   quo
);
	import lgts_pkg::*;

	localparam int CNT_BITS = $clog2(Q_BITS);

	logic                busy_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DEN_BITS-1:0] r_q;
	logic [DEN_BITS-1:0] den_q;
	logic [Q_BITS-1:0]   n_q;
	logic [Q_BITS-1:0]   q_q;
	logic                sat_q;
	logic [DEN_BITS:0]   rr;
	logic [DEN_BITS:0]   diff;
	logic                ge;

	assign rr   = {r_q, n_q[Q_BITS-1]};
	assign ge   = rr >= {1'b0, den_q};
	assign diff = rr - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_BITS'(1);
			if (cnt_q == CNT_BITS'(Q_BITS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= CMP_BITS'(num) >= {den, FRAC_BITS'(0)};
			r_q   <= DEN_BITS'(num >> FRAC_BITS);
			n_q   <= {num[FRAC_BITS-1:0], (Q_BITS - FRAC_BITS)'(0)};
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			r_q <= ge ? diff[DEN_BITS-1:0] : rr[DEN_BITS-1:0];
			n_q <= {n_q[Q_BITS-2:0], 1'b0};
			q_q <= {q_q[Q_BITS-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = sat_q ? {Q_BITS{1'b1}} : q_q;

endmodule

[hw/rtl/lgts_datapath.sv]
// Datapath of the topic sampler: count memories, weight memory, dividers,
// multiplier, accumulator, configuration and the result register.
// Depends on lgts_pkg, lgts_div and lgts_result_if.
`timescale 1ns / 1ps
module lgts_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lgts_pkg::cmd_t                 cmd,
	output lgts_pkg::stat_t                status,
	input  logic [lgts_pkg::MODE_W-1:0]    tok_mode,
	input  logic [lgts_pkg::DOC_W-1:0]     tok_doc,
	input  logic [lgts_pkg::WORD_W-1:0]    tok_word,
	input  logic [lgts_pkg::TOPIC_W-1:0]   tok_topic,
	input  logic [lgts_pkg::RND_W-1:0]     tok_rnd,
	input  logic                           cfg_we,
	input  logic [lgts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lgts_pkg::CFG_W-1:0]     cfg_data,
	lgts_result_if.source                  result
);
	import lgts_pkg::*;

	logic [PRIOR_W-1:0] alpha_q, beta_q;
	logic [KREG_W-1:0]  topics_q;
	logic [VREG_W-1:0]  vocab_q;
	logic [PRIOR_W-1:0] a_eff, b_eff;
	logic [VREG_W-1:0]  v_eff;
	logic [K_BITS-1:0]  k_eff;
	logic [DEN_BITS-1:0] vb_q, ka_q;

	logic [MODE_W-1:0]  mode_q;
	logic [DOC_W-1:0]   doc_q;
	logic [WORD_W-1:0]  word_q;
	logic [TOPIC_W-1:0] topic_q;
	logic [RND_W-1:0]   rnd_q;

	logic [CLR_BITS-1:0]   clr_q;
	logic [TOPIC_BITS-1:0] i_q;
	logic [TOPIC_BITS-1:0] tsel;

	logic [COUNT_BITS-1:0] wt_mem [VOCAB*TOPICS];
	logic [COUNT_BITS-1:0] dt_mem [DOCS*TOPICS];
	logic [COUNT_BITS-1:0] tt_mem [TOPICS];
	logic [COUNT_BITS-1:0] dl_mem [DOCS];
	logic [Q_BITS-1:0]     cw_mem [TOPICS];

	logic [WT_ADDR_BITS-1:0] wt_addr;
	logic [DT_ADDR_BITS-1:0] dt_addr;
	logic [TOPIC_BITS-1:0]   tt_addr;
	logic [DOC_BITS-1:0]     dl_addr;
	logic                    mem_we;
	logic [COUNT_BITS-1:0]   wt_rd_q, dt_rd_q, tt_rd_q, dl_rd_q;
	logic [COUNT_BITS-1:0]   wt_wd, dt_wd, tt_wd, dl_wd;
	logic [COUNT_BITS-1:0]   dl_q;
	logic [Q_BITS-1:0]       cw_rd_q;

	logic                busy_w, busy_d;
	logic [Q_BITS-1:0]   qw, qd;
	logic [2*Q_BITS-1:0] prod_q;
	logic [Q_BITS-1:0]   w, acc_q, acc_next, thr_q;
	logic [Q_BITS:0]     sum;
	logic [Q_BITS+RND_W-1:0] thr_prod;

	logic [TOPIC_W-1:0] res_topic_q, out_topic_q;
	logic [OUT_W-1:0]   res_nw_q, res_tt_q, res_nd_q, res_dl_q;
	logic [OUT_W-1:0]   out_nw_q, out_tt_q, out_nd_q, out_dl_q;
	logic               out_valid_q;

	function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] c);
		return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
	endfunction

	function automatic logic [COUNT_BITS-1:0] cnt_dec(input logic [COUNT_BITS-1:0] c);
		return (c == '0) ? c : c - COUNT_BITS'(1);
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= ALPHA_RESET;
			beta_q   <= BETA_RESET;
			topics_q <= TOPICS_RESET;
			vocab_q  <= VOCAB_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHA:  alpha_q  <= cfg_data[PRIOR_W-1:0];
				REG_BETA:   beta_q   <= cfg_data[PRIOR_W-1:0];
				REG_TOPICS: topics_q <= cfg_data[KREG_W-1:0];
				REG_VOCAB:  vocab_q  <= cfg_data[VREG_W-1:0];
				default: ;
			endcase
		end
	end

	assign a_eff = (alpha_q == '0) ? PRIOR_W'(1) : alpha_q;
	assign b_eff = (beta_q == '0) ? PRIOR_W'(1) : beta_q;
	assign v_eff = (vocab_q == '0) ? VREG_W'(1) : vocab_q;
	assign k_eff = (topics_q == '0) ? K_BITS'(1) :
		((32'(topics_q) > TOPICS) ? K_BITS'(TOPICS) : K_BITS'(topics_q));

	always_ff @(posedge clk) begin
		vb_q <= DEN_BITS'(v_eff) * DEN_BITS'(b_eff);
		ka_q <= DEN_BITS'(k_eff) * DEN_BITS'(a_eff);
	end

	// token capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= tok_mode;
			doc_q   <= tok_doc;
			word_q  <= tok_word;
			topic_q <= tok_topic;
			rnd_q   <= tok_rnd;
		end else if (cmd.pick) begin
			topic_q <= TOPIC_W'(i_q);
		end
	end

	// clear sweep and topic index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			i_q   <= '0;
		end else begin
			if (cmd.clr_wr)
				clr_q <= clr_q + CLR_BITS'(1);
			if (cmd.wr_dec || cmd.thr)
				i_q <= '0;
			else if (cmd.i_inc)
				i_q <= i_q + TOPIC_BITS'(1);
		end
	end

	assign tsel = (cmd.addr_sel == ADDR_LOOP) ? i_q : topic_q[TOPIC_BITS-1:0];

	always_comb begin
		if (cmd.addr_sel == ADDR_CLEAR) begin
			wt_addr = clr_q[WT_ADDR_BITS-1:0];
			dt_addr = clr_q[DT_ADDR_BITS-1:0];
			tt_addr = clr_q[TOPIC_BITS-1:0];
			dl_addr = clr_q[DOC_BITS-1:0];
		end else begin
			wt_addr = {word_q[WORD_BITS-1:0], tsel};
			dt_addr = {doc_q[DOC_BITS-1:0], tsel};
			tt_addr = tsel;
			dl_addr = doc_q[DOC_BITS-1:0];
		end
	end

	always_comb begin
		if (cmd.clr_wr) begin
			wt_wd = '0;
			dt_wd = '0;
			tt_wd = '0;
			dl_wd = '0;
		end else if (cmd.wr_inc) begin
			wt_wd = cnt_inc(wt_rd_q);
			dt_wd = cnt_inc(dt_rd_q);
			tt_wd = cnt_inc(tt_rd_q);
			dl_wd = cnt_inc(dl_rd_q);
		end else begin
			wt_wd = cnt_dec(wt_rd_q);
			dt_wd = cnt_dec(dt_rd_q);
			tt_wd = cnt_dec(tt_rd_q);
			dl_wd = cnt_dec(dl_rd_q);
		end
	end

	assign mem_we = cmd.clr_wr || cmd.wr_inc || cmd.wr_dec;

	always_ff @(posedge clk) begin
		if (mem_we)
			wt_mem[wt_addr] <= wt_wd;
		if (cmd.rd_cnt)
			wt_rd_q <= wt_mem[wt_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			dt_mem[dt_addr] <= dt_wd;
		if (cmd.rd_cnt)
			dt_rd_q <= dt_mem[dt_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			tt_mem[tt_addr] <= tt_wd;
		if (cmd.rd_cnt)
			tt_rd_q <= tt_mem[tt_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			dl_mem[dl_addr] <= dl_wd;
		if (cmd.rd_cnt)
			dl_rd_q <= dl_mem[dl_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.acc)
			cw_mem[i_q] <= acc_next;
		if (cmd.scan_rd)
			cw_rd_q <= cw_mem[i_q];
	end

	// weights
	lgts_div u_div_w (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   ({1'b0, wt_rd_q, FRAC_BITS'(0)} + NUM_BITS'(b_eff)),
		.den   (DEN_BITS'({tt_rd_q, FRAC_BITS'(0)}) + vb_q),
		.busy  (busy_w),
		.quo   (qw)
	);

	lgts_div u_div_d (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   ({1'b0, dt_rd_q, FRAC_BITS'(0)} + NUM_BITS'(a_eff)),
		.den   (DEN_BITS'({dl_q, FRAC_BITS'(0)}) + ka_q),
		.busy  (busy_d),
		.quo   (qd)
	);

	assign w        = (|prod_q[2*Q_BITS-1:Q_BITS+FRAC_BITS]) ? {Q_BITS{1'b1}} :
		prod_q[Q_BITS+FRAC_BITS-1:FRAC_BITS];
	assign sum      = {1'b0, acc_q} + {1'b0, w};
	assign acc_next = sum[Q_BITS] ? {Q_BITS{1'b1}} : sum[Q_BITS-1:0];
	assign thr_prod = (Q_BITS + RND_W)'(acc_q) * (Q_BITS + RND_W)'(rnd_q);

	always_ff @(posedge clk) begin
		if (cmd.mul)
			prod_q <= (2*Q_BITS)'(qw) * (2*Q_BITS)'(qd);
		if (cmd.wr_dec) begin
			acc_q <= '0;
			dl_q  <= cnt_dec(dl_rd_q);
		end else if (cmd.acc) begin
			acc_q <= acc_next;
		end
		if (cmd.thr)
			thr_q <= thr_prod[Q_BITS+RND_W-1:RND_W];
	end

	// result
	always_ff @(posedge clk) begin
		if (cmd.res_zero) begin
			res_topic_q <= topic_q;
			res_nw_q    <= '0;
			res_tt_q    <= '0;
			res_nd_q    <= '0;
			res_dl_q    <= '0;
		end else if (cmd.res_rd) begin
			res_topic_q <= topic_q;
			res_nw_q    <= OUT_W'(wt_rd_q);
			res_tt_q    <= OUT_W'(tt_rd_q);
			res_nd_q    <= OUT_W'(dt_rd_q);
			res_dl_q    <= OUT_W'(dl_rd_q);
		end else if (cmd.wr_inc) begin
			res_topic_q <= topic_q;
			res_nw_q    <= OUT_W'(wt_wd);
			res_tt_q    <= OUT_W'(tt_wd);
			res_nd_q    <= OUT_W'(dt_wd);
			res_dl_q    <= OUT_W'(dl_wd);
		end
		if (cmd.out_load) begin
			out_topic_q <= res_topic_q;
			out_nw_q    <= res_nw_q;
			out_tt_q    <= res_tt_q;
			out_nd_q    <= res_nd_q;
			out_dl_q    <= res_dl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	assign result.valid            = out_valid_q;
	assign result.new_topic        = out_topic_q;
	assign result.word_topic_count = out_nw_q;
	assign result.topic_total      = out_tt_q;
	assign result.doc_topic_count  = out_nd_q;
	assign result.doc_length       = out_dl_q;

	assign status.bad_index = (32'(doc_q) >= DOCS) || (32'(word_q) >= VOCAB) ||
		(32'(topic_q) >= TOPICS);
	assign status.mode     = mode_t'(mode_q);
	assign status.div_done = !busy_w && !busy_d;
	assign status.hit      = cw_rd_q > thr_q;
	assign status.i_last   = K_BITS'(i_q) == (k_eff - K_BITS'(1));
	assign status.clr_last = clr_q == {CLR_BITS{1'b1}};
	assign status.out_free = !out_valid_q || result.ready;

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !status.div_done)
		else $error("divider idle right after start");
	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick |=> (K_BITS'(topic_q) < k_eff))
		else $error("picked topic outside topics in use");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result.valid)
		else $error("loaded result not presented");

endmodule

[hw/rtl/lgts_ctrl.sv]
// Controller of the topic sampler: sequences clear sweep, count updates,
// the per-topic weight loop and the draw scan. Depends on lgts_pkg.
`timescale 1ns / 1ps
module lgts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_valid,
	output logic            tok_ready,
	input  lgts_pkg::stat_t status,
	output lgts_pkg::cmd_t  cmd
);
	import lgts_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_TOK_DATA, S_LOOP_RD, S_LOOP_DATA, S_LOOP_DIV,
		S_LOOP_MUL, S_THRESH, S_SCAN_RD, S_SCAN_CHK, S_NEW_RD, S_NEW_DATA, S_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR:     if (status.clr_last) state_q <= S_IDLE;
				S_IDLE:      if (tok_valid) state_q <= S_CHECK;
				S_CHECK:     state_q <= status.bad_index ? S_FINISH : S_TOK_DATA;
				S_TOK_DATA:  state_q <= (status.mode == MODE_RESAMPLE) ? S_LOOP_RD : S_FINISH;
				S_LOOP_RD:   state_q <= S_LOOP_DATA;
				S_LOOP_DATA: state_q <= S_LOOP_DIV;
				S_LOOP_DIV:  if (status.div_done) state_q <= S_LOOP_MUL;
				S_LOOP_MUL:  state_q <= status.i_last ? S_THRESH : S_LOOP_RD;
				S_THRESH:    state_q <= S_SCAN_RD;
				S_SCAN_RD:   state_q <= S_SCAN_CHK;
				S_SCAN_CHK:  state_q <= (status.hit || status.i_last) ? S_NEW_RD : S_SCAN_RD;
				S_NEW_RD:    state_q <= S_NEW_DATA;
				S_NEW_DATA:  state_q <= S_FINISH;
				S_FINISH:    if (status.out_free) state_q <= S_IDLE;
				default:     state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd       = '0;
		cmd.addr_sel = ADDR_TOKEN;
		tok_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr   = 1'b1;
				cmd.addr_sel = ADDR_CLEAR;
			end
			S_IDLE: begin
				tok_ready   = 1'b1;
				cmd.capture = tok_valid;
			end
			S_CHECK: begin
				if (status.bad_index)
					cmd.res_zero = 1'b1;
				else
					cmd.rd_cnt = 1'b1;
			end
			S_TOK_DATA: begin
				unique case (status.mode)
					MODE_ADD:      cmd.wr_inc = 1'b1;
					MODE_RESAMPLE: cmd.wr_dec = 1'b1;
					default:       cmd.res_rd = 1'b1;
				endcase
			end
			S_LOOP_RD: begin
				cmd.rd_cnt   = 1'b1;
				cmd.addr_sel = ADDR_LOOP;
			end
			S_LOOP_DATA: cmd.div_start = 1'b1;
			S_LOOP_DIV:  cmd.mul = status.div_done;
			S_LOOP_MUL: begin
				cmd.acc   = 1'b1;
				cmd.i_inc = !status.i_last;
			end
			S_THRESH:  cmd.thr = 1'b1;
			S_SCAN_RD: cmd.scan_rd = 1'b1;
			S_SCAN_CHK: begin
				if (status.hit || status.i_last)
					cmd.pick = 1'b1;
				else
					cmd.i_inc = 1'b1;
			end
			S_NEW_RD:   cmd.rd_cnt = 1'b1;
			S_NEW_DATA: cmd.wr_inc = 1'b1;
			S_FINISH:   cmd.out_load = status.out_free;
			default: ;
		endcase
	end

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_inc && cmd.wr_dec) && !(cmd.clr_wr && cmd.capture))
		else $error("conflicting memory commands");

endmodule
